/* sv/tpss_pkg.sv */
// Package for the touch panel sample sequencer.
// Holds the item codes, the result item type and the constructors of result items.
// Depends on nothing.
package tpss_pkg;

    localparam int SAMPLE_BITS           = 10;
    localparam int SAMPLES_PER_POINT_DEF = 5;
    localparam int MAX_RESULTS           = 6;
    localparam int RES_CNT_W             = 3;
    localparam int TICKS_W               = 16;
    localparam logic [TICKS_W-1:0] RESAMPLE_TICKS_RESET = 16'd10;

    localparam logic [1:0] FUNC_PEN_CHANGE = 2'd0;
    localparam logic [1:0] FUNC_CONV_DONE  = 2'd1;
    localparam logic [1:0] FUNC_TICK       = 2'd2;

    localparam logic OUT_EVENT   = 1'b0;
    localparam logic OUT_COMMAND = 1'b1;

    localparam logic [2:0] EV_PRESSURE = 3'd0;
    localparam logic [2:0] EV_TOUCH    = 3'd1;
    localparam logic [2:0] EV_SYNC     = 3'd2;
    localparam logic [2:0] EV_XPOS     = 3'd3;
    localparam logic [2:0] EV_YPOS     = 3'd4;

    localparam logic [1:0] MODE_WAIT_DOWN = 2'd0;
    localparam logic [1:0] MODE_WAIT_UP   = 2'd1;
    localparam logic [1:0] MODE_MEASURE   = 2'd2;

    typedef struct packed {
        logic                   out_kind;
        logic [2:0]             event_kind;
        logic [SAMPLE_BITS-1:0] event_value;
        logic [1:0]             touch_mode;
        logic                   start_conversion;
        logic                   last;
    } result_t;

    function automatic result_t mk_event(logic [2:0] kind, logic [SAMPLE_BITS-1:0] value);
        result_t r;
        r                  = '0;
        r.out_kind         = OUT_EVENT;
        r.event_kind       = kind;
        r.event_value      = value;
        return r;
    endfunction

    function automatic result_t mk_command(logic [1:0] mode, logic start);
        result_t r;
        r                  = '0;
        r.out_kind         = OUT_COMMAND;
        r.touch_mode       = mode;
        r.start_conversion = start;
        return r;
    endfunction

endpackage

/* sv/tpss_if.sv */
// Valid/ready channel interfaces for the touch panel sample sequencer.
// Depends on tpss_pkg for the field widths.
interface tpss_in_if
    import tpss_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic                   pen_lifted;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;

    modport source (output valid, func, pen_lifted, x_sample, y_sample, input ready);
    modport sink   (input valid, func, pen_lifted, x_sample, y_sample, output ready);
endinterface

interface tpss_out_if
    import tpss_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   out_kind;
    logic [2:0]             event_kind;
    logic [SAMPLE_BITS-1:0] event_value;
    logic [1:0]             touch_mode;
    logic                   start_conversion;
    logic                   last;

    modport source (output valid, out_kind, event_kind, event_value, touch_mode,
                    start_conversion, last, input ready);
    modport sink   (input valid, out_kind, event_kind, event_value, touch_mode,
                    start_conversion, last, output ready);
endinterface

/* sv/touch_panel_sample_sequencer.sv */
// Top level of the touch panel sample sequencer: input stage, decision logic and result burst.
// Depends on tpss_pkg and on the channel interfaces in tpss_if.sv.
//
//   Channel     Direction  Handshake          Carries
//   sample_in   sink       valid/ready        func, pen_lifted, x_sample, y_sample
//   result_out  source     valid/ready        one result item per handshake
//   cfg         sink       cfg_wr_en only     resample_ticks
//
// An item waits in the input register, then loads its whole burst of zero to six
// results into the result register together; they leave one per cycle unless the output stalls.
// A new item is taken while the burst drains, and the next burst loads in the cycle the
// last result of the previous one is taken.
// Reset clears the state, the counters and the valid flags; the burst register holds no reset.
// A stall on the result side holds the burst and, once the input register is full, the input.
module touch_panel_sample_sequencer
    import tpss_pkg::*;
#(
    parameter int SAMPLES_PER_POINT = SAMPLES_PER_POINT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [TICKS_W-1:0] cfg_wr_data,
    tpss_in_if.sink            sample_in,
    tpss_out_if.source         result_out
);

    localparam int DIV_L    = $clog2(SAMPLES_PER_POINT);
    localparam int ACC_W    = SAMPLE_BITS + DIV_L;
    localparam int DIV_S    = ACC_W + DIV_L;
    localparam int DIV_M_W  = DIV_S + 1;
    localparam int PROD_W   = ACC_W + DIV_M_W;
    localparam int CNT_W    = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
    localparam longint DIV_M_VAL =
        ((longint'(1) << DIV_S) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_VAL);
    localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(SAMPLES_PER_POINT - 1);

    logic [TICKS_W-1:0]     resample_ticks_reg;

    logic                   stage_valid_reg;
    logic [1:0]             stage_func_reg;
    logic                   stage_lifted_reg;
    logic [SAMPLE_BITS-1:0] stage_x_reg;
    logic [SAMPLE_BITS-1:0] stage_y_reg;

    logic [CNT_W-1:0]       sample_index_reg, sample_index_next;
    logic [ACC_W-1:0]       x_acc_reg, x_acc_next;
    logic [ACC_W-1:0]       y_acc_reg, y_acc_next;
    logic [TICKS_W-1:0]     countdown_reg, countdown_next;

    result_t                slot_reg [MAX_RESULTS];
    result_t                slot_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;

    result_t                new_res [MAX_RESULTS];
    logic [RES_CNT_W-1:0]   new_cnt;

    logic                   in_fire;
    logic                   out_fire;
    logic                   load;
    logic                   completing;
    logic [ACC_W-1:0]       x_sum;
    logic [ACC_W-1:0]       y_sum;
    logic [PROD_W-1:0]      x_prod;
    logic [PROD_W-1:0]      y_prod;
    logic [SAMPLE_BITS-1:0] x_avg;
    logic [SAMPLE_BITS-1:0] y_avg;
    logic [TICKS_W-1:0]     reload_ticks;

    assign out_fire         = result_out.valid && result_out.ready;
    assign load             = stage_valid_reg && ((cnt_reg == '0) || (out_fire && cnt_reg == 1));
    assign sample_in.ready  = !stage_valid_reg || load;
    assign in_fire          = sample_in.valid && sample_in.ready;

    assign result_out.valid            = (cnt_reg != '0);
    assign result_out.out_kind         = slot_reg[0].out_kind;
    assign result_out.event_kind       = slot_reg[0].event_kind;
    assign result_out.event_value      = slot_reg[0].event_value;
    assign result_out.touch_mode       = slot_reg[0].touch_mode;
    assign result_out.start_conversion = slot_reg[0].start_conversion;
    assign result_out.last             = slot_reg[0].last;

    // The averages divide by a reciprocal that is exact over the whole accumulator range.
    assign x_sum        = x_acc_reg + ACC_W'(stage_x_reg);
    assign y_sum        = y_acc_reg + ACC_W'(stage_y_reg);
    assign x_prod       = PROD_W'(x_sum) * PROD_W'(DIV_M);
    assign y_prod       = PROD_W'(y_sum) * PROD_W'(DIV_M);
    assign x_avg        = x_prod[DIV_S +: SAMPLE_BITS];
    assign y_avg        = y_prod[DIV_S +: SAMPLE_BITS];
    assign completing   = (sample_index_reg == LAST_INDEX);
    assign reload_ticks = (resample_ticks_reg != '0) ? resample_ticks_reg : TICKS_W'(1);

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            new_res[i] = '0;
        end
        new_cnt           = '0;
        sample_index_next = sample_index_reg;
        x_acc_next        = x_acc_reg;
        y_acc_next        = y_acc_reg;
        countdown_next    = countdown_reg;

        unique case (stage_func_reg)
            FUNC_PEN_CHANGE:
            begin
                new_res[0] = mk_event(EV_PRESSURE, SAMPLE_BITS'(!stage_lifted_reg));
                new_res[1] = mk_event(EV_TOUCH, SAMPLE_BITS'(!stage_lifted_reg));
                new_res[2] = mk_event(EV_SYNC, '0);
                new_res[3] = stage_lifted_reg ? mk_command(MODE_WAIT_DOWN, 1'b0)
                                              : mk_command(MODE_MEASURE, 1'b1);
                new_cnt    = RES_CNT_W'(4);
            end
            FUNC_CONV_DONE:
            begin
                if (stage_lifted_reg)
                begin
                    new_res[0]        = mk_command(MODE_WAIT_DOWN, 1'b0);
                    new_res[1]        = mk_event(EV_PRESSURE, '0);
                    new_res[2]        = mk_event(EV_TOUCH, '0);
                    new_res[3]        = mk_event(EV_SYNC, '0);
                    new_cnt           = RES_CNT_W'(4);
                    sample_index_next = '0;
                    x_acc_next        = '0;
                    y_acc_next        = '0;
                end
                else if (completing)
                begin
                    new_res[0]        = mk_event(EV_XPOS, x_avg);
                    new_res[1]        = mk_event(EV_YPOS, y_avg);
                    new_res[2]        = mk_event(EV_PRESSURE, SAMPLE_BITS'(1));
                    new_res[3]        = mk_event(EV_TOUCH, SAMPLE_BITS'(1));
                    new_res[4]        = mk_event(EV_SYNC, '0);
                    new_res[5]        = mk_command(MODE_WAIT_UP, 1'b0);
                    new_cnt           = RES_CNT_W'(MAX_RESULTS);
                    sample_index_next = '0;
                    x_acc_next        = '0;
                    y_acc_next        = '0;
                    countdown_next    = reload_ticks;
                end
                else
                begin
                    new_res[0]        = mk_command(MODE_MEASURE, 1'b1);
                    new_cnt           = RES_CNT_W'(1);
                    sample_index_next = sample_index_reg + 1'b1;
                    x_acc_next        = x_sum;
                    y_acc_next        = y_sum;
                end
            end
            FUNC_TICK:
            begin
                if (countdown_reg != '0)
                begin
                    countdown_next = countdown_reg - 1'b1;
                    if (countdown_reg == TICKS_W'(1))
                    begin
                        new_res[0] = stage_lifted_reg ? mk_command(MODE_WAIT_DOWN, 1'b0)
                                                      : mk_command(MODE_MEASURE, 1'b1);
                        new_cnt    = RES_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                new_cnt = '0;
            end
        endcase

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            new_res[i].last = (RES_CNT_W'(i) == RES_CNT_W'(new_cnt - 1'b1));
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        cnt_next = cnt_reg;
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_next[i] = new_res[i];
            end
            cnt_next = new_cnt;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resample_ticks_reg <= RESAMPLE_TICKS_RESET;
            stage_valid_reg    <= 1'b0;
            sample_index_reg   <= '0;
            x_acc_reg          <= '0;
            y_acc_reg          <= '0;
            countdown_reg      <= '0;
            cnt_reg            <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                resample_ticks_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (load)
            begin
                sample_index_reg <= sample_index_next;
                x_acc_reg        <= x_acc_next;
                y_acc_reg        <= y_acc_next;
                countdown_reg    <= countdown_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_func_reg   <= sample_in.func;
            stage_lifted_reg <= sample_in.pen_lifted;
            stage_x_reg      <= sample_in.x_sample;
            stage_y_reg      <= sample_in.y_sample;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result burst count exceeds its capacity");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && slot_reg[0].last) |-> (cnt_reg == RES_CNT_W'(1)))
        else $error("last result item shown while more remain in the burst");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_index_reg <= LAST_INDEX)
        else $error("sample index beyond the samples of one point");

    a_point_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (load && stage_func_reg == FUNC_CONV_DONE && !stage_lifted_reg && completing)
        |=> (cnt_reg == RES_CNT_W'(MAX_RESULTS) && countdown_reg != '0))
        else $error("completed point did not load a full burst and arm the countdown");

endmodule
